@@ hw/rtl/clbr_pkg.sv @@
// ----------------------------------------------------------------------------
// clbr_pkg
// Shared sizes, codes and types for the convolution layer engine.
// ----------------------------------------------------------------------------
package clbr_pkg;

  // Layer geometry
  localparam int unsigned KERNEL_SIZE  = 5;
  localparam int unsigned IN_SIZE      = 32;
  localparam int unsigned IN_CHANNELS  = 8;
  localparam int unsigned OUT_CHANNELS = 16;

  localparam int unsigned OUT_LAST   = IN_SIZE - KERNEL_SIZE;  // highest output row/col
  localparam int unsigned FEAT_DEPTH = IN_CHANNELS * IN_SIZE * IN_SIZE;
  localparam int unsigned WGT_DEPTH  = IN_CHANNELS * OUT_CHANNELS * KERNEL_SIZE * KERNEL_SIZE;
  localparam int unsigned FEAT_AW    = $clog2(FEAT_DEPTH);
  localparam int unsigned WGT_AW     = $clog2(WGT_DEPTH);
  localparam int unsigned CH_W       = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int unsigned KS_W       = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
  localparam int unsigned OC_W       = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

  // Fixed-point formats
  localparam int unsigned DATA_W = 16;  // Q4.12
  localparam int unsigned PROD_W = 32;  // Q8.24
  localparam int unsigned ACC_W  = 40;  // Q16.24
  localparam logic signed [DATA_W-1:0] Q_ONE = 16'sh1000;  // 1.0 in Q4.12

  // Request actions
  localparam logic [1:0] ACT_WEIGHT  = 2'd0;
  localparam logic [1:0] ACT_BIAS    = 2'd1;
  localparam logic [1:0] ACT_PIXEL   = 2'd2;
  localparam logic [1:0] ACT_COMPUTE = 2'd3;

  // Configuration register indexes
  localparam logic REG_RELU_ENABLE  = 1'b0;
  localparam logic REG_RESULT_SHIFT = 1'b1;

  // Control from sequencer to the shared MAC
  typedef struct packed {
    logic clr;   // zero the accumulator
    logic vld;   // operands valid this cycle
    logic last;  // final operand pair of the sum
  } mac_ctrl_t;

endpackage

@@ hw/rtl/conv_layer_bias_relu_top.sv @@
// ----------------------------------------------------------------------------
// conv_layer_bias_relu_top
// One valid-mode convolution layer with bias and optional ReLU, Q4.12 data,
// computed one output at a time through a single shared MAC.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------
// request   | start / busy          | action, in/out channel, row, col, value
// result    | res_valid_o strobe    | channel, row, col, activation, saturated
// config    | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// Load requests (weight, bias, pixel) write their store directly and never raise busy.
// A compute request raises busy while it makes 200 MAC issues
// (IN_CHANNELS * KERNEL_SIZE^2, one store read per cycle from each RAM port),
// one bias issue, and drains the RAM/multiply/accumulate/output pipeline.
// Out-of-range requests are dropped without a result. The result strobe is
// high one cycle; the receiver cannot stall it. Reset clears control and
// config; stores hold garbage until written.
//
module conv_layer_bias_relu_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // request
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             action_i,
  input  logic [2:0]                             in_channel_i,
  input  logic [3:0]                             out_channel_i,
  input  logic [4:0]                             row_i,
  input  logic [4:0]                             col_i,
  input  logic signed [15:0]                     value_i,
  // result
  output logic                                   res_valid_o,
  output logic [3:0]                             res_channel_o,
  output logic [4:0]                             res_row_o,
  output logic [4:0]                             res_col_o,
  output logic signed [15:0]                     activation_o,
  output logic                                   saturated_o,
  // config
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_idx_i,
  input  logic [3:0]                             cfg_wdata_i
);
  import clbr_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // taking requests
  localparam logic [1:0] ST_MAC  = 2'd1;  // issuing pixel*weight pairs
  localparam logic [1:0] ST_BIAS = 2'd2;  // issuing bias*1.0
  localparam logic [1:0] ST_WAIT = 2'd3;  // draining the pipeline

  logic [1:0] state_q, state_d;

  // config registers
  logic       relu_q;
  logic [3:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relu_q  <= 1'b1;
      shift_q <= 4'd12;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RELU_ENABLE:  relu_q  <= cfg_wdata_i[0];
        REG_RESULT_SHIFT: shift_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request decode
  logic accept;
  logic wgt_ok, bias_ok, pix_ok, comp_ok;

  assign accept = start & ~busy;

  assign wgt_ok  = (32'(in_channel_i) < IN_CHANNELS) && (32'(out_channel_i) < OUT_CHANNELS)
                && (32'(row_i) < KERNEL_SIZE) && (32'(col_i) < KERNEL_SIZE);
  assign bias_ok = 32'(out_channel_i) < OUT_CHANNELS;
  assign pix_ok  = (32'(in_channel_i) < IN_CHANNELS) && (32'(row_i) < IN_SIZE)
                && (32'(col_i) < IN_SIZE);
  assign comp_ok = (32'(out_channel_i) < OUT_CHANNELS) && (32'(row_i) <= OUT_LAST)
                && (32'(col_i) <= OUT_LAST);

  logic wr_wgt, wr_bias, wr_pix, go;

  assign wr_wgt  = accept && (action_i == ACT_WEIGHT) && wgt_ok;
  assign wr_bias = accept && (action_i == ACT_BIAS) && bias_ok;
  assign wr_pix  = accept && (action_i == ACT_PIXEL) && pix_ok;
  assign go      = accept && (action_i == ACT_COMPUTE) && comp_ok;

  // bias store: small flop array, one read port
  logic signed [DATA_W-1:0] bias_q [OUT_CHANNELS];

  always_ff @(posedge clk_i) begin
    if (wr_bias) begin
      bias_q[out_channel_i[OC_W-1:0]] <= value_i;
    end
  end

  // latched compute request and loop counters
  logic [3:0]      oc_q;
  logic [4:0]      row_q, col_q;
  logic [CH_W-1:0] ic_q;
  logic [KS_W-1:0] kr_q, kc_q;
  logic            kc_end, kr_end, ic_end;

  assign kc_end = 32'(kc_q) == KERNEL_SIZE - 1;
  assign kr_end = 32'(kr_q) == KERNEL_SIZE - 1;
  assign ic_end = 32'(ic_q) == IN_CHANNELS - 1;

  always_ff @(posedge clk_i) begin
    if (go) begin
      oc_q  <= out_channel_i;
      row_q <= row_i;
      col_q <= col_i;
      ic_q  <= '0;
      kr_q  <= '0;
      kc_q  <= '0;
    end else if (state_q == ST_MAC) begin
      if (kc_end) begin
        kc_q <= '0;
        if (kr_end) begin
          kr_q <= '0;
          ic_q <= ic_q + 1'b1;
        end else begin
          kr_q <= kr_q + 1'b1;
        end
      end else begin
        kc_q <= kc_q + 1'b1;
      end
    end
  end

  // sequencer
  logic mac_done;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (go) state_d = ST_MAC;
      ST_MAC:  if (ic_end && kr_end && kc_end) state_d = ST_BIAS;
      ST_BIAS: state_d = ST_WAIT;
      ST_WAIT: if (mac_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != ST_IDLE;

  // store addressing: writes while idle, reads while computing
  logic [FEAT_AW-1:0] feat_addr;
  logic [WGT_AW-1:0]  wgt_addr;

  always_comb begin
    if (busy) begin
      feat_addr = FEAT_AW'((32'(ic_q) * IN_SIZE + 32'(row_q) + 32'(kr_q)) * IN_SIZE
                           + 32'(col_q) + 32'(kc_q));
      wgt_addr  = WGT_AW'(((32'(ic_q) * OUT_CHANNELS + 32'(oc_q)) * KERNEL_SIZE
                           + 32'(kr_q)) * KERNEL_SIZE + 32'(kc_q));
    end else begin
      feat_addr = FEAT_AW'((32'(in_channel_i) * IN_SIZE + 32'(row_i)) * IN_SIZE
                           + 32'(col_i));
      wgt_addr  = WGT_AW'(((32'(in_channel_i) * OUT_CHANNELS + 32'(out_channel_i))
                           * KERNEL_SIZE + 32'(row_i)) * KERNEL_SIZE + 32'(col_i));
    end
  end

  logic [DATA_W-1:0] feat_rdata, wgt_rdata;

  clbr_ram #(
    .DEPTH (FEAT_DEPTH),
    .WIDTH (DATA_W)
  ) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pix),
    .addr_i  (feat_addr),
    .wdata_i (value_i),
    .rdata_o (feat_rdata)
  );

  clbr_ram #(
    .DEPTH (WGT_DEPTH),
    .WIDTH (DATA_W)
  ) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wr_wgt),
    .addr_i  (wgt_addr),
    .wdata_i (value_i),
    .rdata_o (wgt_rdata)
  );

  // operand stage: aligned with the registered RAM read data
  logic s1_vld_q, s1_bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_bias_q <= 1'b0;
    end else begin
      s1_vld_q  <= (state_q == ST_MAC) || (state_q == ST_BIAS);
      s1_bias_q <= state_q == ST_BIAS;
    end
  end

  // bias goes through the same multiplier as bias * 1.0, which is bias << 12
  logic signed [DATA_W-1:0] op_a, op_b;
  mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]  acc;

  assign op_a = s1_bias_q ? bias_q[oc_q[OC_W-1:0]] : $signed(feat_rdata);
  assign op_b = s1_bias_q ? Q_ONE : $signed(wgt_rdata);

  assign mac_ctrl.clr  = go;
  assign mac_ctrl.vld  = s1_vld_q;
  assign mac_ctrl.last = s1_bias_q;

  clbr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (op_a),
    .b_i    (op_b),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // ReLU, shift and saturate, then register the result
  logic signed [DATA_W-1:0] post_act;
  logic                     post_sat;

  clbr_post u_post (
    .acc_i     (acc),
    .relu_en_i (relu_q),
    .shift_i   (shift_q),
    .act_o     (post_act),
    .sat_o     (post_sat)
  );

  logic                     res_vld_q;
  logic [3:0]               res_ch_q;
  logic [4:0]               res_row_q, res_col_q;
  logic signed [DATA_W-1:0] res_act_q;
  logic                     res_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= mac_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_done) begin
      res_ch_q  <= oc_q;
      res_row_q <= row_q;
      res_col_q <= col_q;
      res_act_q <= post_act;
      res_sat_q <= post_sat;
    end
  end

  assign res_valid_o   = res_vld_q;
  assign res_channel_o = res_ch_q;
  assign res_row_o     = res_row_q;
  assign res_col_o     = res_col_q;
  assign activation_o  = res_act_q;
  assign saturated_o   = res_sat_q;

endmodule

@@ hw/rtl/clbr_ram.sv @@
// ----------------------------------------------------------------------------
// clbr_ram
// Single-port RAM, one read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module clbr_ram #(
  parameter  int unsigned DEPTH = 8192,
  parameter  int unsigned WIDTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/clbr_mac.sv @@
// ----------------------------------------------------------------------------
// clbr_mac
// Shared multiply-accumulate: registered 16x16 product, 40-bit wrapping sum.
// ----------------------------------------------------------------------------
module clbr_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  clbr_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [clbr_pkg::DATA_W-1:0]      a_i,
  input  logic signed [clbr_pkg::DATA_W-1:0]      b_i,
  output logic signed [clbr_pkg::ACC_W-1:0]       acc_o,
  output logic                                    done_o
);
  import clbr_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     pvld_q, plast_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q  <= 1'b0;
      plast_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      pvld_q  <= ctrl_i.vld;
      plast_q <= ctrl_i.vld & ctrl_i.last;
      done_q  <= pvld_q & plast_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (pvld_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

@@ hw/rtl/clbr_post.sv @@
// ----------------------------------------------------------------------------
// clbr_post
// Output stage: optional ReLU, floor right shift, saturate to Q4.12.
// ----------------------------------------------------------------------------
module clbr_post (
  input  logic signed [clbr_pkg::ACC_W-1:0]  acc_i,
  input  logic                               relu_en_i,
  input  logic [3:0]                         shift_i,
  output logic signed [clbr_pkg::DATA_W-1:0] act_o,
  output logic                               sat_o
);
  import clbr_pkg::*;

  localparam logic signed [ACC_W-1:0] MAX_V = 40'sd32767;
  localparam logic signed [ACC_W-1:0] MIN_V = -40'sd32768;

  logic signed [ACC_W-1:0] rect;
  logic signed [ACC_W-1:0] shifted;

  always_comb begin
    rect    = (relu_en_i && acc_i[ACC_W-1]) ? '0 : acc_i;
    shifted = rect >>> shift_i;  // arithmetic shift floors
    if (shifted > MAX_V) begin
      act_o = 16'sh7fff;
      sat_o = 1'b1;
    end else if (shifted < MIN_V) begin
      act_o = -16'sh8000;
      sat_o = 1'b1;
    end else begin
      act_o = shifted[DATA_W-1:0];
      sat_o = 1'b0;
    end
  end

endmodule
